### hw/rtl/fqvp_pkg.sv
package fqvp_pkg;

	// lane and pipeline geometry
	localparam int NUM_LANES = 4;
	localparam int DIV_STEPS = 30;
	// s1 translate, s2 rotate products, s3 depth, divider, s34 scale products
	localparam int LANE_LAT  = 3 + DIV_STEPS + 1;

	// screen and depth constants, 16.16
	localparam logic [31:0] CENTER_X_FIX = 32'(160) << 16;
	localparam logic [31:0] CENTER_Y_FIX = 32'(100) << 16;
	localparam logic signed [31:0] MIN_DEPTH = 32'sd262144;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_POS_X   = 3'd0,
		REG_POS_Y   = 3'd1,
		REG_POS_Z   = 3'd2,
		REG_SINE    = 3'd3,
		REG_COSINE  = 3'd4,
		REG_SCALE_X = 3'd5,
		REG_SCALE_Y = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [17:0] sine;
		logic [17:0] cosine;
		logic [30:0] scale_x;
		logic [30:0] scale_y;
	} view_cfg_t;

	// what one lane hands to the merge stage
	typedef struct packed {
		logic        ok;
		logic [31:0] xprod;
		logic [31:0] yprod;
	} lane_res_t;

endpackage

### hw/rtl/floor_quad_view_projection.sv
// an accepted request passes the lane stages and the output register before its result reaches the master side
// throughput: one quad per cycle unless stalled; four corner lanes, each with two 30-stage dividers
// the whole pipeline stalls only while a finished result is held by m_tready low
// reset (arst_n low, asynchronous) empties the pipeline and loads register defaults
module floor_quad_view_projection (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
	// corner3_x, corner3_y, quad_height
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// screen0_x, screen0_y, screen1_x, screen1_y, screen2_x, screen2_y,
	// screen3_x, screen3_y
	output logic [127:0] m_tdata,
	// visible
	output logic         m_tuser
);
	import fqvp_pkg::*;

	view_cfg_t             cfg_q;
	logic                  en;
	logic [LANE_LAT-1:0]   vld_q;
	lane_res_t             res [NUM_LANES];
	logic                  all_ok;
	logic [127:0]          data_next;
	logic [31:0]           sum_x [NUM_LANES];
	logic [31:0]           sum_y [NUM_LANES];
	logic                  out_valid_q;
	logic [127:0]          out_data_q;
	logic                  out_vis_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x   <= '0;
			cfg_q.pos_y   <= '0;
			cfg_q.pos_z   <= '0;
			cfg_q.sine    <= '0;
			cfg_q.cosine  <= 18'd65536;
			cfg_q.scale_x <= 31'd10485760;
			cfg_q.scale_y <= 31'd10485760;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POS_X:   cfg_q.pos_x   <= cfg_data;
				REG_POS_Y:   cfg_q.pos_y   <= cfg_data;
				REG_POS_Z:   cfg_q.pos_z   <= cfg_data;
				REG_SINE:    cfg_q.sine    <= cfg_data[17:0];
				REG_COSINE:  cfg_q.cosine  <= cfg_data[17:0];
				REG_SCALE_X: cfg_q.scale_x <= cfg_data[30:0];
				REG_SCALE_Y: cfg_q.scale_y <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// pipeline advances unless the output holds an untaken result
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// corner lanes
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		fqvp_lane u_lane (
			.clk      (clk),
			.en       (en),
			.cfg      (cfg_q),
			.corner_x (s_tdata[64*i +: 32]),
			.corner_y (s_tdata[64*i+32 +: 32]),
			.height   (s_tdata[256 +: 32]),
			.res      (res[i])
		);
	end

	// valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LANE_LAT-2:0], s_tvalid};
		end
	end

	// merge: center offsets and cull when any corner is too close
	always_comb begin
		all_ok = 1'b1;
		for (int i = 0; i < NUM_LANES; i++) begin
			all_ok   = all_ok & res[i].ok;
			sum_x[i] = CENTER_X_FIX + res[i].xprod;
			sum_y[i] = CENTER_Y_FIX + res[i].yprod;
			data_next[32*i +: 16]    = all_ok ? sum_x[i][31:16] : 16'd0;
			data_next[32*i+16 +: 16] = all_ok ? sum_y[i][31:16] : 16'd0;
		end
		for (int i = 0; i < NUM_LANES; i++) begin
			if (!all_ok) begin
				data_next[32*i +: 32] = 32'd0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_q[LANE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= data_next;
			out_vis_q  <= all_ok;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_vis_q;

endmodule

### hw/rtl/fqvp_div.sv
module fqvp_div (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] num,
	input  logic [31:0] den,
	output logic [30:0] quo
);
	import fqvp_pkg::*;

	logic [31:0]          rem_s  [DIV_STEPS];
	logic [DIV_STEPS-1:0] low_s  [DIV_STEPS];
	logic [31:0]          den_s  [DIV_STEPS];
	logic [DIV_STEPS-1:0] q_s    [DIV_STEPS];
	logic                 sat_s  [DIV_STEPS];

	logic [31:0]          rem_in [DIV_STEPS];
	logic [DIV_STEPS-1:0] low_in [DIV_STEPS];
	logic [31:0]          den_in [DIV_STEPS];
	logic [DIV_STEPS-1:0] q_in   [DIV_STEPS];
	logic                 sat_in [DIV_STEPS];
	logic [32:0]          trial  [DIV_STEPS];
	logic                 fits   [DIV_STEPS];

	// stage inputs: first stage from the ports, others from the previous stage
	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			if (k == 0) begin
				rem_in[k] = {15'd0, num[30:14]};
				low_in[k] = {num[13:0], 16'd0};
				den_in[k] = den;
				q_in[k]   = '0;
				sat_in[k] = {15'd0, num[30:14]} >= den;
			end else begin
				rem_in[k] = rem_s[k-1];
				low_in[k] = low_s[k-1];
				den_in[k] = den_s[k-1];
				q_in[k]   = q_s[k-1];
				sat_in[k] = sat_s[k-1];
			end
			trial[k] = {rem_in[k], low_in[k][DIV_STEPS-1]};
			fits[k]  = trial[k] >= {1'b0, den_in[k]};
		end
	end

	// one quotient bit per stage, restoring form
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				rem_s[k] <= fits[k] ? 32'(trial[k] - {1'b0, den_in[k]}) : trial[k][31:0];
				low_s[k] <= {low_in[k][DIV_STEPS-2:0], 1'b0};
				den_s[k] <= den_in[k];
				q_s[k]   <= {q_in[k][DIV_STEPS-2:0], fits[k]};
				sat_s[k] <= sat_in[k];
			end
		end
	end

	assign quo = sat_s[DIV_STEPS-1] ? 31'h7FFF_FFFF : 31'(q_s[DIV_STEPS-1]);

endmodule

### hw/rtl/fqvp_lane.sv
module fqvp_lane (
	input  logic                clk,
	input  logic                en,
	input  fqvp_pkg::view_cfg_t cfg,
	input  logic [31:0]         corner_x,
	input  logic [31:0]         corner_y,
	input  logic [31:0]         height,
	output fqvp_pkg::lane_res_t res
);
	import fqvp_pkg::*;

	logic [31:0] tx_s1, ty_s1, rz_s1;
	logic [31:0] txs_s2, tyc_s2, txc_s2, tys_s2, rz_s2;
	logic [31:0] side_s3, depth_s3, rz_s3;
	logic        ok_s3;
	logic [31:0] side_d [DIV_STEPS];
	logic [31:0] rz_d   [DIV_STEPS];
	logic        ok_d   [DIV_STEPS];
	logic [30:0] qx, qy;
	logic [31:0] ys;
	logic signed [49:0] m_txs, m_tyc, m_txc, m_tys;
	logic signed [63:0] m_x, m_y;
	logic [31:0] xprod_s34, yprod_s34;
	logic        ok_s34;

	// rotation products
	always_comb begin
		m_txs = $signed(tx_s1) * $signed(cfg.sine);
		m_tyc = $signed(ty_s1) * $signed(cfg.cosine);
		m_txc = $signed(tx_s1) * $signed(cfg.cosine);
		m_tys = $signed(ty_s1) * $signed(cfg.sine);
	end

	// translate, rotate, depth test
	always_ff @(posedge clk) begin
		if (en) begin
			tx_s1    <= corner_x - cfg.pos_x;
			ty_s1    <= corner_y - cfg.pos_y;
			rz_s1    <= height - cfg.pos_z;
			txs_s2   <= m_txs[47:16];
			tyc_s2   <= m_tyc[47:16];
			txc_s2   <= m_txc[47:16];
			tys_s2   <= m_tys[47:16];
			rz_s2    <= rz_s1;
			side_s3  <= txs_s2 - tyc_s2;
			depth_s3 <= txc_s2 + tys_s2;
			ok_s3    <= $signed(txc_s2 + tys_s2) >= MIN_DEPTH;
			rz_s3    <= rz_s2;
		end
	end

	fqvp_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (cfg.scale_x),
		.den (depth_s3),
		.quo (qx)
	);

	fqvp_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (cfg.scale_y),
		.den (depth_s3),
		.quo (qy)
	);

	// side, height and depth test wait alongside the divider
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				side_d[k] <= (k == 0) ? side_s3 : side_d[k-1];
				rz_d[k]   <= (k == 0) ? rz_s3 : rz_d[k-1];
				ok_d[k]   <= (k == 0) ? ok_s3 : ok_d[k-1];
			end
		end
	end

	// scale products
	always_comb begin
		ys  = 32'd0 - {1'b0, qy};
		m_x = $signed(side_d[DIV_STEPS-1]) * $signed({1'b0, qx});
		m_y = $signed(rz_d[DIV_STEPS-1]) * $signed(ys);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xprod_s34 <= m_x[47:16];
			yprod_s34 <= m_y[47:16];
			ok_s34    <= ok_d[DIV_STEPS-1];
		end
	end

	assign res = '{ok: ok_s34, xprod: xprod_s34, yprod: yprod_s34};

endmodule

### hw/rtl/fqvp_chk.sv
module fqvp_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic         m_tuser
);

	// a culled quad carries all-zero coordinates
	a_cull_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 128'd0)
		else $error("culled quad with nonzero coordinates");

	// input side stalls exactly while a result is held
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// a held result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a held result does not change
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind floor_quad_view_projection fqvp_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
